// ===== sv/thrm_pkg.sv =====
// Shared types, widths and the log2 knot table of the thermistor converter.
`default_nettype none
package thrm_pkg;

  localparam int ADC_W     = 16;                     // ADC sample width
  localparam int RD_W      = 24;                     // pull-up resistance width
  localparam int COEF_W    = 24;                     // Q8.16 coefficients
  localparam int OFS_W     = 16;                     // temperature offset width
  localparam int TEMP_W    = 16;                     // result width
  localparam int RQ_FRAC   = 8;                      // resistance held as Q.8 ohms
  localparam int NUM_W     = ADC_W + RD_W + RQ_FRAC; // dividend and quotient width
  localparam int DEN_W     = ADC_W;                  // divisor width
  localparam int E_W       = $clog2(NUM_W);          // leading-one position width
  localparam int TAB_BITS  = 8;                      // knot index bits
  localparam int KNOT_N    = (1 << TAB_BITS) + 1;
  localparam int KIDX_W    = TAB_BITS + 1;
  localparam int KNOT_W    = 17;                     // knots run 0..65536
  localparam int REM_W     = 30 - TAB_BITS;          // interpolation fraction
  localparam int LOG2_W    = 24;                     // log2 R in Q.16
  localparam int LN_W      = 24;                     // ln R in Q8.16
  localparam int LN2_W     = 32;
  localparam logic signed [LN2_W-1:0] LN2_Q30 = 32'sd744261118;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_OPEN  = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  typedef enum logic [2:0] {
    REG_FULL_SCALE = 3'd0,
    REG_DIVIDER    = 3'd1,
    REG_INTERCEPT  = 3'd2,
    REG_SLOPE      = 3'd3,
    REG_OFFSET     = 3'd4
  } reg_idx_t;

  // Side information that travels with every item down the pipeline
  typedef struct packed {
    logic valid;
    logic shorted;
    logic open_ckt;
  } tag_t;

  typedef struct packed {
    logic [ADC_W-1:0]         full_scale;
    logic [RD_W-1:0]          rdiv;
    logic signed [COEF_W-1:0] intercept;
    logic signed [COEF_W-1:0] slope;
    logic signed [OFS_W-1:0]  offset;
  } cfg_t;

  typedef logic [KNOT_N-1:0][KNOT_W-1:0] knot_tab_t;

  // Fraction bits of log2(x), x in [1,2) as Q.30, by repeated squaring
  function automatic logic [KNOT_W-1:0] log2_frac_sq(input logic [63:0] x0);
    logic [63:0]       x;
    logic [KNOT_W-1:0] y;
    x = x0;
    y = '0;
    for (int k = 0; k < 16; k++) begin
      x = (x * x) >> 30;
      y = {y[KNOT_W-2:0], 1'b0};
      if (x >= (64'd1 << 31)) begin
        y[0] = 1'b1;
        x = x >> 1;
      end
    end
    return y;
  endfunction

  function automatic knot_tab_t build_knots();
    knot_tab_t tab;
    for (int i = 0; i < KNOT_N; i++) begin
      if (i >= (1 << TAB_BITS)) begin
        tab[i] = KNOT_W'(65536);
      end else begin
        tab[i] = log2_frac_sq((64'd1 << 30) + (64'(i) << (30 - TAB_BITS)));
      end
    end
    return tab;
  endfunction

  localparam knot_tab_t KNOTS = build_knots();

endpackage
`default_nettype wire

// ===== sv/thermistor_adc_to_temperature.sv =====
// Top level of the thermistor ADC sample to temperature converter.
// Converts one raw divider sample per clock, while the output does not stall,
// into temperature in 1/16 degree C with a status code (0 ok, 1 shorted,
// 2 open, 3 saturated). Each sample passes through the 48-stage restoring
// divider that forms the resistance in Q.8 ohms, then a six-stage normalizer,
// the log2 knot table with interpolation, the ln 2 scaling and the linear map.
// A stall on the output freezes the whole pipeline, so in_ready follows
// out_ready whenever a result is waiting. Write configuration only while idle.
`default_nettype none
module thermistor_adc_to_temperature (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [4:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [thrm_pkg::ADC_W-1:0]         adc_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [thrm_pkg::TEMP_W-1:0] temperature,
  output logic [1:0]                         sensor_status
);
  import thrm_pkg::*;

  cfg_t cfg;
  tag_t tag_in, tag_div, tag_log, tag_d, tag_p;
  logic en;
  logic [NUM_W-1:0] quo;
  logic signed [LN_W-1:0] lnq;
  logic signed [LN_W:0] d;
  logic signed [LN_W+COEF_W:0] p;
  logic signed [LN_W+COEF_W+1:0] pr;
  logic signed [LN_W+COEF_W-27:0] tq;
  logic signed [LN_W+COEF_W-26:0] tsum;

  thrm_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // Whole pipeline moves unless a result is held
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign tag_in.valid    = in_valid;
  assign tag_in.shorted  = (adc_sample == '0);
  assign tag_in.open_ckt = (adc_sample != '0) && (adc_sample >= cfg.full_scale);

  thrm_div u_div (
    .clk, .rst, .en, .tag_in,
    .sample(adc_sample), .rdiv(cfg.rdiv), .full_scale(cfg.full_scale),
    .tag_out(tag_div), .quo
  );

  thrm_log u_log (
    .clk, .rst, .en, .tag_in(tag_div), .rq(quo), .tag_out(tag_log), .lnq
  );

  // Round half up, add offset
  assign pr   = $signed({p[LN_W+COEF_W], p}) + $signed((LN_W+COEF_W+2)'(1 << 27));
  assign tq   = pr[LN_W+COEF_W+1:28];
  assign tsum = $signed({tq[LN_W+COEF_W-27], tq})
              + $signed((LN_W+COEF_W-25)'(cfg.offset));

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_d     <= '0;
      tag_p     <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      tag_d     <= tag_log;
      tag_p     <= tag_d;
      out_valid <= tag_p.valid;
    end
  end

  // Subtract intercept, multiply by slope, then flag shorted or open sensors, saturate and hold the result
  always_ff @(posedge clk) begin
    if (en) begin
      d <= $signed({lnq[LN_W-1], lnq}) - $signed({cfg.intercept[COEF_W-1], cfg.intercept});
      p <= d * cfg.slope;
      if (tag_p.shorted) begin
        temperature   <= TEMP_W'(16'sh7FFF);
        sensor_status <= ST_SHORT;
      end else if (tag_p.open_ckt) begin
        temperature   <= TEMP_W'(16'sh8000);
        sensor_status <= ST_OPEN;
      end else if (tsum > $signed((LN_W+COEF_W-25)'(32767))) begin
        temperature   <= TEMP_W'(16'sh7FFF);
        sensor_status <= ST_SAT;
      end else if (tsum < -$signed((LN_W+COEF_W-25)'(32768))) begin
        temperature   <= TEMP_W'(16'sh8000);
        sensor_status <= ST_SAT;
      end else begin
        temperature   <= tsum[TEMP_W-1:0];
        sensor_status <= ST_OK;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/thrm_regs.sv =====
// APB-style configuration registers of the thermistor converter.
`default_nettype none
module thrm_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output thrm_pkg::cfg_t     cfg
);
  import thrm_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.full_scale <= ADC_W'(4096);
      cfg.rdiv       <= RD_W'(4700);
      cfg.intercept  <= COEF_W'(723066);
      cfg.slope      <= -COEF_W'(1900713);
      cfg.offset     <= -OFS_W'(368);
    end else if (wr) begin
      case (idx)
        REG_FULL_SCALE: cfg.full_scale <= pwdata[ADC_W-1:0];
        REG_DIVIDER:    cfg.rdiv       <= pwdata[RD_W-1:0];
        REG_INTERCEPT:  cfg.intercept  <= $signed(pwdata[COEF_W-1:0]);
        REG_SLOPE:      cfg.slope      <= $signed(pwdata[COEF_W-1:0]);
        REG_OFFSET:     cfg.offset     <= $signed(pwdata[OFS_W-1:0]);
        default: ;
      endcase
    end
  end

  // Read back, signed registers sign-extended
  always_comb begin
    case (idx)
      REG_FULL_SCALE: prdata = 32'(cfg.full_scale);
      REG_DIVIDER:    prdata = 32'(cfg.rdiv);
      REG_INTERCEPT:  prdata = 32'(cfg.intercept);
      REG_SLOPE:      prdata = 32'(cfg.slope);
      REG_OFFSET:     prdata = 32'(cfg.offset);
      default:        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/thrm_div.sv =====
// Resistance pipeline: dividend product, then one restoring quotient bit per stage.
`default_nettype none
module thrm_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  thrm_pkg::tag_t               tag_in,
  input  logic [thrm_pkg::ADC_W-1:0]   sample,
  input  logic [thrm_pkg::RD_W-1:0]    rdiv,
  input  logic [thrm_pkg::ADC_W-1:0]   full_scale,
  output thrm_pkg::tag_t               tag_out,
  output logic [thrm_pkg::NUM_W-1:0]   quo
);
  import thrm_pkg::*;

  tag_t             tag_q [0:NUM_W];
  logic [DEN_W-1:0] rem_q [0:NUM_W];
  logic [NUM_W-1:0] nq_q  [0:NUM_W];
  logic [DEN_W-1:0] den_q [0:NUM_W];
  logic [ADC_W+RD_W-1:0] prod;

  assign prod = sample * rdiv;

  // Load dividend sample*Rdiv*256 and divisor full_scale-sample
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_q[0] <= '0;
    end else if (en) begin
      tag_q[0] <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nq_q[0]  <= {prod, {RQ_FRAC{1'b0}}};
      rem_q[0] <= '0;
      den_q[0] <= full_scale - sample;
    end
  end

  // One quotient bit per stage
  for (genvar g = 0; g < NUM_W; g++) begin : g_step
    logic [DEN_W:0] trial;
    logic           fits;

    assign trial = {rem_q[g], nq_q[g][NUM_W-1]};
    assign fits  = trial >= {1'b0, den_q[g]};

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_q[g+1] <= '0;
      end else if (en) begin
        tag_q[g+1] <= tag_q[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[g+1] <= fits ? DEN_W'(trial - {1'b0, den_q[g]}) : trial[DEN_W-1:0];
        nq_q[g+1]  <= {nq_q[g][NUM_W-2:0], fits};
        den_q[g+1] <= den_q[g];
      end
    end
  end

  assign tag_out = tag_q[NUM_W];
  assign quo     = nq_q[NUM_W];

endmodule
`default_nettype wire

// ===== sv/thrm_log.sv =====
// Natural log pipeline: staged normalize, knot lookup, interpolation, scale by ln 2.
`default_nettype none
module thrm_log (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  thrm_pkg::tag_t                    tag_in,
  input  logic [thrm_pkg::NUM_W-1:0]        rq,
  output thrm_pkg::tag_t                    tag_out,
  output logic signed [thrm_pkg::LN_W-1:0]  lnq
);
  import thrm_pkg::*;

  tag_t             ntag [0:E_W];
  logic [NUM_W-1:0] nv   [0:E_W];
  logic [E_W-1:0]   ne   [0:E_W];

  tag_t tag_t1, tag_t2, tag_t3, tag_t4, tag_t5;

  logic [KNOT_W-1:0]   k0_t1, diff_t1, k0_t2;
  logic [REM_W-1:0]    rem_t1;
  logic [E_W-1:0]      e_t1, e_t2;
  logic [KNOT_W+REM_W-1:0] prod_t2;
  logic signed [LOG2_W-1:0] log2q_t3;
  logic signed [LOG2_W+LN2_W-1:0] lnp_t4;

  logic [TAB_BITS-1:0] idx;
  logic [KIDX_W-1:0]   idx1;
  logic signed [E_W:0] eoff;
  logic signed [LOG2_W-1:0] log2q;

  // Take zero resistance as one LSB; leading one starts at the top
  always_ff @(posedge clk) begin
    if (rst) begin
      ntag[0] <= '0;
    end else if (en) begin
      ntag[0] <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nv[0] <= (rq == '0) ? NUM_W'(1) : rq;
      ne[0] <= E_W'(NUM_W - 1);
    end
  end

  // Shift left by halving amounts while the top bits are clear
  for (genvar k = 0; k < E_W; k++) begin : g_norm
    localparam int AMT = 1 << (E_W - 1 - k);
    logic clear;

    assign clear = (nv[k][NUM_W-1 -: AMT] == '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        ntag[k+1] <= '0;
      end else if (en) begin
        ntag[k+1] <= ntag[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nv[k+1] <= clear ? (nv[k] << AMT) : nv[k];
        ne[k+1] <= clear ? E_W'(ne[k] - E_W'(AMT)) : ne[k];
      end
    end
  end

  assign idx  = nv[E_W][NUM_W-2 -: TAB_BITS];
  assign idx1 = KIDX_W'(idx) + KIDX_W'(1);

  assign eoff  = $signed({1'b0, e_t2}) - $signed((E_W+1)'(RQ_FRAC));
  assign log2q = $signed(LOG2_W'($signed({eoff, 16'b0})))
               + $signed(LOG2_W'(k0_t2))
               + $signed(LOG2_W'(prod_t2[KNOT_W+REM_W-1:REM_W]));

  // Advance the tags of the back stages
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_t1 <= '0;
      tag_t2 <= '0;
      tag_t3 <= '0;
      tag_t4 <= '0;
      tag_t5 <= '0;
    end else if (en) begin
      tag_t1 <= ntag[E_W];
      tag_t2 <= tag_t1;
      tag_t3 <= tag_t2;
      tag_t4 <= tag_t3;
      tag_t5 <= tag_t4;
    end
  end

  // Knot lookup, interpolation product, sum, ln 2 scaling, floor shift
  always_ff @(posedge clk) begin
    if (en) begin
      k0_t1    <= KNOTS[KIDX_W'(idx)];
      diff_t1  <= KNOTS[idx1] - KNOTS[KIDX_W'(idx)];
      rem_t1   <= nv[E_W][NUM_W-2-TAB_BITS -: REM_W];
      e_t1     <= ne[E_W];
      k0_t2    <= k0_t1;
      e_t2     <= e_t1;
      prod_t2  <= diff_t1 * rem_t1;
      log2q_t3 <= log2q;
      lnp_t4   <= log2q_t3 * LN2_Q30;
      lnq      <= lnp_t4[30 +: LN_W];
    end
  end

  assign tag_out = tag_t5;

endmodule
`default_nettype wire
